// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file stbt_chk.sv
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== sv/stbt_pkg.sv =====
// types, constants and codes of the swept box time of impact block
// no dependencies
`timescale 1ns / 1ps
package stbt_pkg;

  localparam int CoordW    = 32;
  localparam int TimeFrac  = 16;
  localparam int TimeW     = TimeFrac + 1;   // unsigned result time
  localparam int TW        = TimeFrac + 3;   // signed time, covers [-2, 2]
  localparam int NumW      = CoordW + 1;
  localparam int RemW      = CoordW + 2;
  localparam int LimitW    = 12;
  localparam int DivSteps  = TimeFrac + 1;
  localparam int DivCntW   = $clog2(DivSteps + 1);
  localparam logic [TW-1:0] TimeOne = TW'(1) << TimeFrac;
  localparam logic [TW-1:0] TimeMax = TW'(2) << TimeFrac;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(1);

  localparam logic ModeStart = 1'b0;
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [CoordW-1:0] box_x_low;
    logic [CoordW-1:0] box_y_low;
    logic [CoordW-1:0] box_z_low;
    logic [CoordW-1:0] box_x_high;
    logic [CoordW-1:0] box_y_high;
    logic [CoordW-1:0] box_z_high;
    logic [CoordW-1:0] move_x;
    logic [CoordW-1:0] move_y;
    logic [CoordW-1:0] move_z;
    logic              last_item;
  } item_t;

  typedef struct packed {
    logic             hit;
    logic [TimeW-1:0] hit_time;
    logic [1:0]       normal_axis;
    logic             normal_positive;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_AXIS, ST_DIV1, ST_DIV2, ST_FINAL, ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load_item;
    logic       load_start;
    logic       clear_best;
    logic       axis_clear;
    logic       set_miss;
    logic       div_start;
    logic       sel_hi;
    logic       store_t1;
    logic       axis_update;
    logic       commit;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic motion_zero;
    logic still;
    logic axis_miss;
    logic div_done;
  } status_t;

endpackage

// ===== sv/stbt_div.sv =====
// restoring divider for the slab times, one quotient bit per cycle
// depends on stbt_pkg
`timescale 1ns / 1ps
module stbt_div import stbt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [NumW-1:0]   num_i,
  input  logic signed [CoordW-1:0] den_i,
  output logic                     done_o,
  output logic signed [TW-1:0]     quot_o
);

  logic [RemW-1:0]    rem_q, rem_d;
  logic [CoordW-1:0]  den_q;
  logic [TimeW-1:0]   quo_q;
  logic [DivCntW-1:0] cnt_q;
  logic               run_q, done_q, neg_q, sat_q;
  logic [NumW-1:0]    num_abs;
  logic [CoordW-1:0]  den_abs;
  logic [RemW-1:0]    den_ext, diff, kept;
  logic               ge;
  logic [TW-1:0]      mag;

  assign num_abs = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign den_abs = den_i[CoordW-1] ? CoordW'(-den_i) : CoordW'(den_i);
  assign den_ext = {2'b00, den_q};
  assign ge      = rem_q >= den_ext;
  assign diff    = rem_q - den_ext;
  assign kept    = ge ? diff : rem_q;
  assign rem_d   = {kept[RemW-2:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RemW'(num_abs);
      den_q <= den_abs;
      neg_q <= num_i[NumW-1] ^ den_i[CoordW-1];
      sat_q <= 1'b0;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[TimeW-2:0], ge};
      // quotient of two or more saturates
      if (cnt_q == '0) sat_q <= rem_q >= {1'b0, den_q, 1'b0};
    end
  end

  assign mag    = sat_q ? TimeMax : TW'(quo_q);
  assign quot_o = neg_q ? TW'(-mag) : mag;
  assign done_o = done_q;

endmodule

// ===== sv/stbt_dp.sv =====
// datapath: sweep state, slab times, running best hit, limit register
// depends on stbt_pkg and stbt_div
`timescale 1ns / 1ps
module stbt_dp import stbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             item_i,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output result_t           result_o
);

  item_t                     item_q;
  logic [LimitW-1:0]         limit_q;
  logic signed [CoordW-1:0]  lo_q [3];
  logic signed [CoordW-1:0]  hi_q [3];
  logic signed [CoordW-1:0]  mot_q [3];
  logic signed [TW-1:0]      enter_q, leave_q, t1_q;
  logic [1:0]                en_axis_q;
  logic                      en_sign_q, miss_q;
  logic [TimeW-1:0]          best_time_q;
  logic [1:0]                best_axis_q;
  logic                      best_sign_q, hit_q;

  logic signed [CoordW-1:0]  a, b, d, p, q;
  logic [CoordW-1:0]         d_abs;
  logic signed [NumW-1:0]    num;
  logic                      div_done;
  logic signed [TW-1:0]      t2, tn, tx;
  logic                      take;

  always_comb begin
    unique case (cmd_i.axis)
      2'd1: begin
        a = lo_q[1]; b = hi_q[1]; d = mot_q[1];
        p = item_q.box_y_low; q = item_q.box_y_high;
      end
      2'd2: begin
        a = lo_q[2]; b = hi_q[2]; d = mot_q[2];
        p = item_q.box_z_low; q = item_q.box_z_high;
      end
      default: begin
        a = lo_q[0]; b = hi_q[0]; d = mot_q[0];
        p = item_q.box_x_low; q = item_q.box_x_high;
      end
    endcase
  end

  assign d_abs = d[CoordW-1] ? CoordW'(-d) : CoordW'(d);
  assign num   = cmd_i.sel_hi ? NumW'(q) - NumW'(a) : NumW'(p) - NumW'(b);

  stbt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (d),
    .done_o  (div_done),
    .quot_o  (t2)
  );

  assign tn   = (t1_q < t2) ? t1_q : t2;
  assign tx   = (t1_q < t2) ? t2 : t1_q;
  assign take = !miss_q && (enter_q <= leave_q) && (enter_q < $signed({2'b00, best_time_q}));

  assign status_o.mode        = item_q.mode;
  assign status_o.last        = item_q.last_item;
  assign status_o.motion_zero = (mot_q[0] == '0) && (mot_q[1] == '0) && (mot_q[2] == '0);
  assign status_o.still       = (d == '0) || (d_abs < CoordW'(limit_q));
  assign status_o.axis_miss   = (b <= p) || (a >= q);
  assign status_o.div_done    = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.axis_clear) begin
      enter_q   <= '0;
      leave_q   <= TimeOne;
      en_axis_q <= AxisX;
      en_sign_q <= 1'b0;
      miss_q    <= 1'b0;
    end else begin
      if (cmd_i.set_miss) miss_q <= 1'b1;
      if (cmd_i.axis_update) begin
        if (tn > enter_q) begin
          enter_q   <= tn;
          en_axis_q <= cmd_i.axis;
          en_sign_q <= d[CoordW-1];
        end
        if (tx < leave_q) leave_q <= tx;
      end
    end
    if (cmd_i.store_t1) t1_q <= t2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      best_time_q <= TimeW'(TimeOne);
      best_axis_q <= AxisX;
      best_sign_q <= 1'b0;
      hit_q       <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        lo_q[k]  <= '0;
        hi_q[k]  <= '0;
        mot_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.load_start) begin
        lo_q[0]  <= item_q.box_x_low;  lo_q[1]  <= item_q.box_y_low;
        lo_q[2]  <= item_q.box_z_low;
        hi_q[0]  <= item_q.box_x_high; hi_q[1]  <= item_q.box_y_high;
        hi_q[2]  <= item_q.box_z_high;
        mot_q[0] <= item_q.move_x;     mot_q[1] <= item_q.move_y;
        mot_q[2] <= item_q.move_z;
      end
      if (cmd_i.clear_best || cmd_i.load_start) begin
        best_time_q <= TimeW'(TimeOne);
        best_axis_q <= AxisX;
        best_sign_q <= 1'b0;
        hit_q       <= 1'b0;
      end else if (cmd_i.commit && take) begin
        best_time_q <= TimeW'(enter_q);
        best_axis_q <= en_axis_q;
        best_sign_q <= en_sign_q;
        hit_q       <= 1'b1;
      end
    end
  end

  assign result_o.hit             = hit_q;
  assign result_o.hit_time        = best_time_q;
  assign result_o.normal_axis     = best_axis_q;
  assign result_o.normal_positive = best_sign_q;

endmodule

// ===== sv/stbt_ctrl.sv =====
// controller: walks the axes of one item and sequences the divider
// depends on stbt_pkg
`timescale 1ns / 1ps
module stbt_ctrl import stbt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output logic    done_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= AxisX;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_DECODE;
      ST_DECODE: begin
        axis_d = AxisX;
        if (status_i.mode == ModeStart || status_i.motion_zero) begin
          state_d = status_i.last ? ST_EMIT : ST_IDLE;
        end else begin
          state_d = ST_AXIS;
        end
      end
      ST_AXIS: begin
        if (!status_i.still) begin
          state_d = ST_DIV1;
        end else if (status_i.axis_miss || axis_q == AxisZ) begin
          state_d = ST_FINAL;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      ST_DIV1: if (status_i.div_done) state_d = ST_DIV2;
      ST_DIV2: begin
        if (status_i.div_done) begin
          if (axis_q == AxisZ) begin
            state_d = ST_FINAL;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = ST_AXIS;
          end
        end
      end
      ST_FINAL: state_d = status_i.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    busy       = state_q != ST_IDLE;
    done_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: cmd_o.load_item = start;
      ST_DECODE: begin
        cmd_o.load_start = status_i.mode == ModeStart;
        cmd_o.axis_clear = 1'b1;
      end
      ST_AXIS: begin
        cmd_o.div_start = !status_i.still;
        cmd_o.set_miss  = status_i.still && status_i.axis_miss;
      end
      ST_DIV1: begin
        cmd_o.store_t1  = status_i.div_done;
        cmd_o.div_start = status_i.div_done;
        cmd_o.sel_hi    = 1'b1;
      end
      ST_DIV2:  cmd_o.axis_update = status_i.div_done;
      ST_FINAL: cmd_o.commit = 1'b1;
      ST_EMIT: begin
        done_o           = 1'b1;
        cmd_o.clear_best = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/swept_box_time_of_impact_top.sv =====
// swept box time of impact: one item in flight, result strobed on done_o
// start item: loaded and decoded, its result emitted if it is last; block item: loaded and
// decoded, and if the sweep moves each axis is tested in turn until a still axis misses,
// each moving axis taking two quotients from the bit-serial divider, before a hit better than
// the best is committed and any result emitted; one item in flight, next start taken once busy drops
// async active-low reset clears the sweep state, best hit and limit (to 1)
`timescale 1ns / 1ps
module swept_box_time_of_impact_top import stbt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  output logic              done_o,
  output result_t           result_o,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  stbt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  stbt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

// ===== sv/stbt_chk.sv =====
// port-level checks of the swept box block, bound to the top level
// depends on stbt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stbt_chk import stbt_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  logic cleared;

  // no-hit beat carries the cleared time and normal
  assign cleared = (result_o.hit_time == TimeW'(TimeOne)) &&
                   (result_o.normal_axis == AxisX) && !result_o.normal_positive;

  `ASSERT_SAME(a_done_busy, done_o, busy)
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ASSERT_NEXT(a_done_pulse, done_o, !done_o)
  `ASSERT_SAME(a_miss_clean, done_o && !result_o.hit, cleared)

endmodule

bind swept_box_time_of_impact_top stbt_chk u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ===== test/swept_box_time_of_impact_top_tb.sv =====
// testbench for swept_box_time_of_impact_top: directed and random sweeps
// predicts hit, time and normal from the slab test; depends on stbt_pkg
`timescale 1ns / 1ps
module swept_box_time_of_impact_top_tb;
  import stbt_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             item_i;
  logic              done_o;
  result_t           result_o;
  logic              cfg_we_i;
  logic [LimitW-1:0] cfg_wdata_i;

  swept_box_time_of_impact_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done_o(done_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state
  logic [LimitW-1:0] still_limit;
  longint mov_lo [3];
  longint mov_hi [3];
  longint motion [3];
  longint best_t;
  logic [1:0] best_ax;
  logic best_pos;
  logic found;

  result_t expected_hits [$];
  int mismatches;
  int gap_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("swept_box_time_of_impact_top_tb: done, errors");
    $finish;
  end

  function automatic longint quotient_q16(longint num, longint den);
    longint an;
    longint ad;
    longint q;
    longint m;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an >= 2 * ad) m = 2 * 65536;
    else begin
      q = (an << 16) / ad;
      m = q;
    end
    return ((num < 0) != (den < 0)) ? -m : m;
  endfunction

  function automatic void reset_best();
    best_t = 65536;
    best_ax = AxisX;
    best_pos = 1'b0;
    found = 1'b0;
  endfunction

  function automatic void slab_test(longint lo [3], longint hi [3]);
    longint enter;
    longint leave;
    longint d;
    longint t1;
    longint t2;
    longint tn;
    longint tx;
    logic [1:0] ax;
    logic pos;
    enter = 0;
    leave = 65536;
    ax = AxisX;
    pos = 1'b0;
    if (motion[0] == 0 && motion[1] == 0 && motion[2] == 0) return;
    for (int k = 0; k < 3; k++) begin
      d = motion[k];
      if (d == 0 || (d < 0 ? -d : d) < longint'(still_limit)) begin
        if (mov_hi[k] <= lo[k] || mov_lo[k] >= hi[k]) return;
        continue;
      end
      t1 = quotient_q16(lo[k] - mov_hi[k], d);
      t2 = quotient_q16(hi[k] - mov_lo[k], d);
      tn = t1 < t2 ? t1 : t2;
      tx = t1 < t2 ? t2 : t1;
      if (tn > enter) begin
        enter = tn;
        ax = 2'(k);
        pos = d > 0 ? 1'b0 : 1'b1;
      end
      if (tx < leave) leave = tx;
    end
    if (enter <= leave && enter < best_t) begin
      best_t = enter;
      best_ax = ax;
      best_pos = pos;
      found = 1'b1;
    end
  endfunction

  function automatic void predict_item(item_t it);
    longint lo [3];
    longint hi [3];
    result_t r;
    lo[0] = longint'($signed(it.box_x_low));
    lo[1] = longint'($signed(it.box_y_low));
    lo[2] = longint'($signed(it.box_z_low));
    hi[0] = longint'($signed(it.box_x_high));
    hi[1] = longint'($signed(it.box_y_high));
    hi[2] = longint'($signed(it.box_z_high));
    if (it.mode == ModeStart) begin
      mov_lo = lo;
      mov_hi = hi;
      motion[0] = longint'($signed(it.move_x));
      motion[1] = longint'($signed(it.move_y));
      motion[2] = longint'($signed(it.move_z));
      reset_best();
    end else begin
      slab_test(lo, hi);
    end
    if (it.last_item) begin
      r.hit = found;
      r.hit_time = TimeW'(best_t);
      r.normal_axis = best_ax;
      r.normal_positive = best_pos;
      expected_hits.push_back(r);
      reset_best();
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = expected_hits.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, result_o);
        end
      end
    end
  end

  task automatic send_item(item_t it);
    if (gap_left > 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      gap_left--;
    end else begin
      // start drops at the previous falling edge, so wait for a falling edge before raising it
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 8);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_item(it);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_hits.size() != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LimitW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    still_limit = v;
  endtask

  function automatic logic [CoordW-1:0] rand_coord(int scale);
    case (scale)
      0: return CoordW'($urandom_range(0, 40000)) - CoordW'(20000);
      1: return CoordW'($urandom_range(0, 1 << 22)) - CoordW'(1 << 21);
      default: return CoordW'($urandom);
    endcase
  endfunction

  function automatic item_t make_item(logic m, logic last, int scale);
    item_t it;
    logic [CoordW-1:0] a;
    logic [CoordW-1:0] b;
    it.mode = m;
    it.last_item = last;
    a = rand_coord(scale);
    b = a + CoordW'($urandom_range(0, 16000));
    it.box_x_low = a;
    it.box_x_high = b;
    a = rand_coord(scale);
    b = a + CoordW'($urandom_range(0, 16000));
    it.box_y_low = a;
    it.box_y_high = b;
    a = rand_coord(scale);
    b = a + CoordW'($urandom_range(0, 16000));
    it.box_z_low = a;
    it.box_z_high = b;
    if (scale == 2 && $urandom_range(0, 1)) begin
      it.box_x_high = $urandom;
      it.box_y_high = $urandom;
      it.box_z_high = $urandom;
    end
    it.move_x = $urandom_range(0, 3) == 0 ? CoordW'($urandom_range(0, 8)) : rand_coord(scale);
    it.move_y = $urandom_range(0, 3) == 0 ? '0 : rand_coord(scale);
    it.move_z = $urandom_range(0, 3) == 0 ? CoordW'(-$urandom_range(0, 8)) : rand_coord(scale);
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    // block before any start, all-zero moving box
    it = make_item(1'b1, 1'b1, 0);
    send_item(it);
    // start with last emits cleared result
    it = make_item(ModeStart, 1'b1, 0);
    send_item(it);
    // overlapping boxes, no entry face
    it = '0;
    it.box_x_high = 32'h1000; it.box_y_high = 32'h1000; it.box_z_high = 32'h1000;
    it.move_x = 32'h800;
    send_item(it);
    it.mode = 1'b1;
    send_item(it);
    // approach along x, y, z from each side
    for (int k = 0; k < 6; k++) begin
      it = '0;
      it.box_x_high = 32'h1000; it.box_y_high = 32'h1000; it.box_z_high = 32'h1000;
      case (k)
        0: it.move_x = 32'h4000;
        1: it.move_x = -32'sh4000;
        2: it.move_y = 32'h4000;
        3: it.move_y = -32'sh4000;
        4: it.move_z = 32'h4000;
        default: it.move_z = -32'sh4000;
      endcase
      send_item(it);
      it.mode = 1'b1;
      it.last_item = 1'b1;
      it.box_x_low = it.move_x[31] ? -32'sh3000 : 32'h2000;
      it.box_x_high = it.box_x_low + 32'h800;
      if (it.move_x == 0) begin it.box_x_low = 32'h0; it.box_x_high = 32'h1000; end
      it.box_y_low = it.move_y == 0 ? 32'h0 : (it.move_y[31] ? -32'sh3000 : 32'h2000);
      it.box_y_high = it.box_y_low + 32'h1000;
      it.box_z_low = it.move_z == 0 ? 32'h0 : (it.move_z[31] ? -32'sh3000 : 32'h2000);
      it.box_z_high = it.box_z_low + 32'h1000;
      send_item(it);
    end
    // extremes of every field, inverted corners
    it = '1;
    it.mode = ModeStart; it.last_item = 1'b0;
    send_item(it);
    it = '0;
    it.mode = 1'b1;
    it.box_x_low = 32'h7fffffff; it.box_y_low = 32'h80000000; it.box_z_low = 32'h7fffffff;
    it.box_x_high = 32'h80000000; it.box_y_high = 32'h7fffffff; it.box_z_high = 32'h80000000;
    it.move_x = 32'h80000000; it.move_y = 32'h7fffffff; it.move_z = 32'h80000000;
    it.last_item = 1'b1;
    send_item(it);
    it.mode = ModeStart; it.last_item = 1'b0;
    send_item(it);
    it.mode = 1'b1; it.last_item = 1'b1;
    send_item(it);
    // zero displacement never hits
    it = '0;
    send_item(it);
    it.mode = 1'b1; it.last_item = 1'b1;
    send_item(it);
  endtask

  task automatic test_random(int n);
    item_t it;
    int scale;
    int len;
    int sent;
    sent = 0;
    while (sent < n) begin
      scale = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      if ($urandom_range(0, 9) == 0) begin
        send_item(make_item(1'($urandom), 1'($urandom), 2));
        sent++;
        continue;
      end
      send_item(make_item(ModeStart, 1'b0, scale));
      len = $urandom_range(1, 5);
      for (int i = 0; i < len; i++)
        send_item(make_item(1'b1, i == len - 1, scale));
      sent += len + 1;
    end
  endtask

  task automatic test_limits();
    logic [LimitW-1:0] settings [4];
    settings = '{LimitW'(0), LimitW'(4095), LimitW'(5), LimitReset};
    foreach (settings[i]) begin
      write_limit(settings[i]);
      test_random(150);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    mismatches = 0;
    gap_left = 0;
    still_limit = LimitReset;
    mov_lo = '{0, 0, 0};
    mov_hi = '{0, 0, 0};
    motion = '{0, 0, 0};
    reset_best();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    // pause until every result is in
    drain();
    test_random(1100);
    test_limits();
    drain();
    if (mismatches == 0 && expected_hits.size() == 0)
      $display("swept_box_time_of_impact_top_tb: done, clean");
    else
      $display("swept_box_time_of_impact_top_tb: done, errors");
    $finish;
  end
endmodule
